/* rtl/rfa_pkg.sv */
// Shared types and constants for the ring fork arbiter.
// No dependencies; every other file in rtl/ imports this package.
package rfa_pkg;

  localparam int unsigned MaxSeats  = 8;
  localparam int unsigned SeatW     = 3;
  localparam int unsigned CountW    = 4;
  localparam logic [CountW-1:0] CountReset = 4'd5;
  localparam logic [CountW-1:0] CountMin   = 4'd2;
  localparam logic [CountW-1:0] CountMax   = 4'd8;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // One result beat as it waits in the output queue.
  typedef struct packed {
    logic [SeatW-1:0] seat;
    logic             last;
  } grant_t;

  // Grants produced by one input item, in delivery order.
  typedef struct packed {
    logic [1:0] cnt;
    grant_t     first;
    grant_t     second;
  } grant_set_t;

endpackage

/* rtl/rfa_core.sv */
// Resource state of the ring and the single-pass request/release logic.
// Depends on rfa_pkg.
module rfa_core import rfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  op_e               op_i,
  input  logic [SeatW-1:0]  seat_i,
  input  logic [CountW-1:0] count_i,
  output grant_set_t        grants_o
);

  logic [MaxSeats-1:0] busy_q, busy_d;
  logic [MaxSeats-1:0] waited_q, waited_d;

  logic [CountW-1:0] n_eff;
  logic [CountW-1:0] s_ext, r_ext, rr_ext, n_m1;
  logic [SeatW-1:0]  l_idx, r_idx, rr_idx;
  logic              in_range;
  logic [1:0]        gcnt;
  logic [SeatW-1:0]  g0, g1;

  always_comb begin
    if (count_i < CountMin) begin
      n_eff = CountMin;
    end else if (count_i > CountMax) begin
      n_eff = CountMax;
    end else begin
      n_eff = count_i;
    end
  end

  // Neighbor indices on a ring of n_eff seats; seat_i < n_eff when used.
  assign s_ext    = {1'b0, seat_i};
  assign in_range = s_ext < n_eff;
  assign n_m1     = n_eff - 4'd1;
  assign r_ext    = s_ext + 4'd1;
  assign r_idx    = (r_ext == n_eff) ? '0 : r_ext[SeatW-1:0];
  assign rr_ext   = {1'b0, r_idx} + 4'd1;
  assign rr_idx   = (rr_ext == n_eff) ? '0 : rr_ext[SeatW-1:0];
  assign l_idx    = (seat_i == '0) ? n_m1[SeatW-1:0] : seat_i - 3'd1;

  always_comb begin
    busy_d   = busy_q;
    waited_d = waited_q;
    gcnt     = 2'd0;
    g0       = '0;
    g1       = '0;
    if (take_i && in_range) begin
      case (op_i)
        OP_REQUEST: begin
          if (busy_d[seat_i]) begin
            waited_d[seat_i] = 1'b1;
          end else begin
            busy_d[seat_i] = 1'b1;
            if (busy_d[r_idx]) begin
              waited_d[r_idx] = 1'b1;
            end else begin
              busy_d[r_idx] = 1'b1;
              g0   = seat_i;
              gcnt = 2'd1;
            end
          end
        end
        OP_RELEASE: begin
          // Left fork: hand it straight to the left neighbor if it waits.
          busy_d[seat_i] = 1'b0;
          if (waited_d[seat_i]) begin
            waited_d[seat_i] = 1'b0;
            busy_d[seat_i]   = 1'b1;
            g0   = l_idx;
            gcnt = 2'd1;
          end
          // Right fork: the right neighbor retries its whole request.
          busy_d[r_idx] = 1'b0;
          if (waited_d[r_idx]) begin
            waited_d[r_idx] = 1'b0;
            busy_d[r_idx]   = 1'b1;
            if (busy_d[rr_idx]) begin
              waited_d[rr_idx] = 1'b1;
            end else begin
              busy_d[rr_idx] = 1'b1;
              if (gcnt == 2'd0) begin
                g0 = r_idx;
              end else begin
                g1 = r_idx;
              end
              gcnt = gcnt + 2'd1;
            end
          end
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= '0;
      waited_q <= '0;
    end else begin
      busy_q   <= busy_d;
      waited_q <= waited_d;
    end
  end

  assign grants_o.cnt         = gcnt;
  assign grants_o.first.seat  = g0;
  assign grants_o.first.last  = (gcnt == 2'd1);
  assign grants_o.second.seat = g1;
  assign grants_o.second.last = 1'b1;

`ifndef SYNTH
  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> (busy_q == $past(busy_q)) && (waited_q == $past(waited_q)))
    else $error("ring state changed without an item");
  a_two_only_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grants_o.cnt == 2'd2) |-> (op_i == OP_RELEASE))
    else $error("two grants from a request");
  a_out_of_range_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && !in_range) |-> (grants_o.cnt == 2'd0))
    else $error("grant for a seat beyond the count");
`endif

endmodule

/* rtl/rfa_out_queue.sv */
// Two-entry result queue: holds the grants of one item and drains one beat a cycle while ready_i is high.
// Depends on rfa_pkg.
module rfa_out_queue import rfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  grant_set_t grants_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output grant_t     head_o
);

  logic [1:0] cnt_q, cnt_d;
  grant_t     slot0_q, slot0_d;
  grant_t     slot1_q, slot1_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign head_o  = slot0_q;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
    if (load_i) begin
      slot0_d = grants_i.first;
      slot1_d = grants_i.second;
      cnt_d   = grants_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue overfilled");
  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> room_o)
    else $error("result queue loaded while still holding beats");
  a_tail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> slot0_q.last)
    else $error("final queued beat not marked last");
`endif

endmodule

/* rtl/ring_fork_arbiter_unit.sv */
// Top level of the ring fork arbiter: input stage, count register, core and result queue.
// Depends on rfa_pkg, rfa_core and rfa_out_queue.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready      | tdata[2:0] seat, tuser operation
//  m_axis   | out | m_axis_tvalid/tready      | tdata[2:0] granted_seat, tlast last
//  cfg      | in  | cfg_valid/cfg_ready       | cfg_data[3:0] seat_count
//
// A beat lands in the input register, then the core logic updates the fork state
// and loads zero, one or two grants into the result queue. The queue drains one beat a
// cycle while m_axis_tready is high, and takes the next item once it is empty or its
// last beat is leaving, so a held item is processed as the previous one's last beat leaves.
// rst_ni clears the fork state, the queue and the input register at once, and loads a
// seat count of five. A stalled m_axis holds the item in the input register, which in
// turn holds s_axis_tready low; cfg is always ready.
module ring_fork_arbiter_unit import rfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [2:0] seat, [7:3] zero
  input  logic       s_axis_tuser,   // [0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [2:0] granted_seat, [7:3] zero
  output logic       m_axis_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data        // seat_count
);

  logic              in_vld_q;
  op_e               in_op_q;
  logic [SeatW-1:0]  in_seat_q;
  logic [CountW-1:0] count_q;
  logic              take;
  logic              room;
  grant_set_t        grants;
  grant_t            head;

  // Process the held item once the queue can take all of its grants.
  assign take          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || take;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      count_q  <= CountReset;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (cfg_valid) begin
        count_q <= cfg_data;
      end
    end
  end

  // Payload of the input register; advance only when the slot frees up.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_seat_q <= s_axis_tdata[SeatW-1:0];
    end
  end

  rfa_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .op_i     (in_op_q),
    .seat_i   (in_seat_q),
    .count_i  (count_q),
    .grants_o (grants)
  );

  rfa_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take),
    .grants_i (grants),
    .room_o   (room),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .head_o   (head)
  );

  assign m_axis_tdata = {5'd0, head.seat};
  assign m_axis_tlast = head.last;

`ifndef SYNTH
  a_stalled_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !take) |=> in_vld_q && $stable(in_seat_q) && $stable(in_op_q))
    else $error("held item lost while the queue was full");
  a_no_take_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> in_vld_q)
    else $error("core stepped without an item");
  a_accept_when_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> s_axis_tready)
    else $error("input slot not reopened after processing");
`endif

endmodule

/* dv/ring_fork_arbiter_unit_test.sv */
// Self-checking bench for ring_fork_arbiter_unit: a directed table, then random request
// and release traffic under changing seat counts, scored against a fork-state predictor.
// Depends on rfa_pkg and the RTL under rtl/.
module ring_fork_arbiter_unit_test;
  import rfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Give up after this many cycles with no beat on any channel.
  localparam int unsigned StallLimit = 2000;
  // Cycles for an item that grants nothing to leave the pipeline.
  localparam int unsigned SettleCycles = 5;
  localparam int unsigned PlanLen = 25;
  localparam int unsigned BlockItems = 80;
  localparam int unsigned BlocksPerPhase = 7;

  // One row of the directed table. Rows with typed set carry their grants here;
  // the rest are scored against the predictor. set_count writes count before the row.
  typedef struct packed {
    logic              set_count;
    logic [CountW-1:0] count;
    op_e               op;
    logic [SeatW-1:0]  seat;
    logic              typed;
    logic [1:0]        n_grants;
    logic [SeatW-1:0]  first_seat;
    logic [SeatW-1:0]  second_seat;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // [2:0] seat, [7:3] zero
  logic             s_axis_tuser;   // [0] operation
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;   // [2:0] granted_seat, [7:3] zero
  logic             m_axis_tlast;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CountW-1:0] cfg_data;

  ring_fork_arbiter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: fork flags, the count register as written, and which seats
  // currently hold both forks (used only to steer the random traffic).
  logic [MaxSeats-1:0] fork_busy;
  logic [MaxSeats-1:0] fork_waited;
  logic [CountW-1:0]   seat_count_reg;
  logic [MaxSeats-1:0] seat_holds;
  logic [SeatW-1:0]    item_grants[$];    // grants of the item just accepted
  grant_t              expected_grants[$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned items_ignored;
  int unsigned grants_checked;
  int unsigned count_writes;
  int unsigned quiet_cycles;

  // Directed table, starting from the reset count of five. The typed rows walk a
  // simple hand-off, the wrap from the top seat to fork zero, a release that hands
  // the left fork to its waiter, and one release that grants two seats.
  plan_row_t test_plan [PlanLen] = '{
    '{1'b0, 4'd0,  OP_REQUEST, 3'd0, 1'b1, 2'd1, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_REQUEST, 3'd1, 1'b1, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_REQUEST, 3'd7, 1'b1, 2'd0, 3'd0, 3'd0},  // seat beyond count
    '{1'b0, 4'd0,  OP_RELEASE, 3'd0, 1'b1, 2'd1, 3'd1, 3'd0},
    '{1'b0, 4'd0,  OP_REQUEST, 3'd4, 1'b1, 2'd1, 3'd4, 3'd0},  // right fork wraps to 0
    '{1'b0, 4'd0,  OP_REQUEST, 3'd3, 1'b1, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_REQUEST, 3'd0, 1'b1, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_RELEASE, 3'd4, 1'b1, 2'd1, 3'd3, 3'd0},
    '{1'b0, 4'd0,  OP_RELEASE, 3'd1, 1'b1, 2'd1, 3'd0, 3'd0},  // release by a seat holding both forks
    '{1'b0, 4'd0,  OP_REQUEST, 3'd2, 1'b1, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_REQUEST, 3'd1, 1'b1, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_RELEASE, 3'd3, 1'b1, 2'd1, 3'd2, 3'd0},
    '{1'b0, 4'd0,  OP_RELEASE, 3'd2, 1'b1, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_REQUEST, 3'd4, 1'b1, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_RELEASE, 3'd0, 1'b1, 2'd2, 3'd4, 3'd1},  // two grants from one release
    // Count changes with forks still held; stale entries stay as they are.
    '{1'b1, 4'd15, OP_REQUEST, 3'd7, 1'b0, 2'd0, 3'd0, 3'd0},  // above range acts as eight
    '{1'b0, 4'd0,  OP_RELEASE, 3'd7, 1'b0, 2'd0, 3'd0, 3'd0},
    '{1'b1, 4'd0,  OP_REQUEST, 3'd1, 1'b0, 2'd0, 3'd0, 3'd0},  // below range acts as two
    '{1'b0, 4'd0,  OP_RELEASE, 3'd1, 1'b0, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_REQUEST, 3'd2, 1'b1, 2'd0, 3'd0, 3'd0},  // seat beyond count
    '{1'b1, 4'd8,  OP_RELEASE, 3'd6, 1'b0, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_REQUEST, 3'd6, 1'b0, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_REQUEST, 3'd7, 1'b0, 2'd0, 3'd0, 3'd0},
    '{1'b0, 4'd0,  OP_RELEASE, 3'd6, 1'b0, 2'd0, 3'd0, 3'd0},
    '{1'b1, 4'd1,  OP_REQUEST, 3'd5, 1'b1, 2'd0, 3'd0, 3'd0}   // seat beyond count
  };

  // Clamp the written count into the range the ring can use.
  function automatic int unsigned ring_size();
    if (seat_count_reg < CountMin) return CountMin;
    if (seat_count_reg > CountMax) return CountMax;
    return seat_count_reg;
  endfunction

  function automatic void note_grant(int unsigned s);
    if (item_grants.size() < 2) begin
      item_grants.push_back(s[SeatW-1:0]);
      seat_holds[s] = 1'b1;
    end
  endfunction

  // Take the left fork or wait on it, then the right fork or wait on it.
  function automatic void claim_forks(int unsigned s, int unsigned n);
    int unsigned r;
    r = (s + 1) % n;
    if (fork_busy[s]) begin
      fork_waited[s] = 1'b1;
      return;
    end
    fork_busy[s] = 1'b1;
    if (fork_busy[r]) begin
      fork_waited[r] = 1'b1;
      return;
    end
    fork_busy[r] = 1'b1;
    note_grant(s);
  endfunction

  // Free both forks: the left fork passes straight to its waiter (the left
  // neighbor), a waiter on the right fork retries its whole request.
  function automatic void drop_forks(int unsigned s, int unsigned n);
    int unsigned l;
    int unsigned r;
    l = (s == 0) ? n - 1 : s - 1;
    r = (s + 1) % n;
    seat_holds[s] = 1'b0;
    fork_busy[s] = 1'b0;
    if (fork_waited[s]) begin
      fork_waited[s] = 1'b0;
      fork_busy[s] = 1'b1;
      note_grant(l);
    end
    fork_busy[r] = 1'b0;
    if (fork_waited[r]) begin
      fork_waited[r] = 1'b0;
      claim_forks(r, n);
    end
  endfunction

  // Advance the predictor by one accepted item; return 0 if the item is ignored.
  function automatic bit arbitrate_item(op_e op, logic [SeatW-1:0] seat);
    int unsigned n;
    n = ring_size();
    item_grants.delete();
    if (seat >= n) return 1'b0;
    if (op == OP_REQUEST) claim_forks(seat, n);
    else drop_forks(seat, n);
    return 1'b1;
  endfunction

  // Queue grant beats in delivery order, marking the final one of the item.
  function automatic void expect_grants(logic [SeatW-1:0] seats[$]);
    grant_t g;
    foreach (seats[k]) begin
      g.seat = seats[k];
      g.last = (k == seats.size() - 1);
      expected_grants.push_back(g);
    end
  endfunction

  // Present one item, hold it until the beat is taken, then predict it.
  // Entered and left just after a rising edge.
  task automatic send_item(input op_e op, input logic [SeatW-1:0] seat, output bit live);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, seat};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    live = arbitrate_item(op, seat);
    items_sent++;
    if (!live) items_ignored++;
  endtask

  // Drain all grants and let an item with no result clear the pipeline.
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seat_count(input logic [CountW-1:0] value);
    wait_until_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seat_count_reg = value;
    count_writes++;
  endtask

  // Result side: score each accepted beat, then pick the next ready at random.
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected grant beat: granted_seat %0d, last %0b",
                 m_axis_tdata[SeatW-1:0], m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          grants_checked++;
          if (m_axis_tdata[SeatW-1:0] !== want.seat) begin
            $error("granted_seat: expected %0d, actual %0d", want.seat,
                   m_axis_tdata[SeatW-1:0]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: end the run when no channel moves a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    plan_row_t        row;
    logic [SeatW-1:0] typed_seats[$];
    logic [CountW-1:0] corner_counts[5];
    logic [SeatW-1:0] seat;
    op_e              op;
    bit               live;
    int unsigned      n;
    int unsigned      live_items;

    corner_counts = '{4'd15, 4'd0, 4'd8, 4'd1, 4'd2};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    fork_busy      = '0;
    fork_waited    = '0;
    seat_holds     = '0;
    seat_count_reg = CountReset;
    src_idle_pct   = 8;
    sink_idle_pct  = 49;
    fail_count     = 0;
    items_sent     = 0;
    items_ignored  = 0;
    grants_checked = 0;
    count_writes   = 0;
    quiet_cycles   = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int i = 0; i < PlanLen; i++) begin
      row = test_plan[i];
      if (row.set_count) write_seat_count(row.count);
      send_item(row.op, row.seat, live);
      if (row.typed) begin
        typed_seats.delete();
        if (row.n_grants > 0) typed_seats.push_back(row.first_seat);
        if (row.n_grants > 1) typed_seats.push_back(row.second_seat);
        expect_grants(typed_seats);
      end else begin
        expect_grants(item_grants);
      end
    end

    // Random traffic in three idling phases: sender light and receiver heavy,
    // then swapped, then both always ready. Each block runs at one seat count,
    // corners first. Most items follow the seat's state (request when not
    // holding, release when holding); the rest are arbitrary, ring or not.
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 49 : 0;
      sink_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 8 : 0;
      for (int blk = 0; blk < BlocksPerPhase; blk++) begin
        if (phase * BlocksPerPhase + blk < 5)
          write_seat_count(corner_counts[phase * BlocksPerPhase + blk]);
        else
          write_seat_count(CountW'($urandom_range(15)));
        n = ring_size();
        live_items = 0;
        while (live_items < BlockItems) begin
          if ($urandom_range(99) < 80) begin
            seat = SeatW'($urandom_range(n - 1));
            op   = seat_holds[seat] ? OP_RELEASE : OP_REQUEST;
          end else begin
            seat = SeatW'($urandom_range(MaxSeats - 1));
            op   = op_e'($urandom_range(1));
          end
          send_item(op, seat, live);
          expect_grants(item_grants);
          if (live) live_items++;
        end
      end
    end

    wait_until_idle();
    repeat (10) @(posedge clk_i);
    if (expected_grants.size() != 0) begin
      $error("%0d grant beats never arrived", expected_grants.size());
      fail_count++;
    end

    $display("Sent %0d items (%0d outside the ring) across %0d seat-count writes.",
             items_sent, items_ignored, count_writes);
    $display("Scored %0d grant beats; %0d mismatches.", grants_checked, fail_count);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
